// File: hdl/lmts_pkg.sv
// ----------------------------------------------------------------------------
// lmts_pkg
// Shared types, command codes and helpers of the LED matrix text scroller.
// ----------------------------------------------------------------------------
package lmts_pkg;

    localparam int ROWS_DEF          = 2;
    localparam int CHARS_PER_ROW_DEF = 8;
    localparam int GLYPHS_DEF        = 128;
    localparam int COLS_PER_CHAR     = 8;

    localparam logic [2:0] CMD_LOAD      = 3'd0;
    localparam logic [2:0] CMD_CLEAR_ALL = 3'd1;
    localparam logic [2:0] CMD_CLEAR_ROW = 3'd2;
    localparam logic [2:0] CMD_WRITE     = 3'd3;
    localparam logic [2:0] CMD_SCROLL    = 3'd4;
    localparam logic [2:0] CMD_READ      = 3'd5;

    localparam logic REG_DOUBLE_SIZE = 1'b0;
    localparam logic REG_FIRST_CODE  = 1'b1;

    localparam logic [7:0] FIRST_CODE_RESET = 8'd32;

    typedef struct packed {
        logic [2:0] command;
        logic       row;
        logic [2:0] char_slot;
        logic [7:0] code;
        logic [2:0] glyph_line;
        logic [7:0] font_byte;
        logic [5:0] frame_column;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] scroll_phase;
    } out_item_t;

    // Each pixel bit becomes two adjacent bits.
    function automatic logic [7:0] expand_nibble(input logic [3:0] nib);
        logic [7:0] res;
        res = 8'd0;
        for (int k = 0; k < 4; k++)
        begin
            res[2*k]   = nib[k];
            res[2*k+1] = nib[k];
        end
        return res;
    endfunction

endpackage

// File: hdl/lmts_ram.sv
// ----------------------------------------------------------------------------
// lmts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/lmts_cell.sv
// ----------------------------------------------------------------------------
// lmts_cell
// One frame byte of a text row; takes its neighbour's byte on a shift.
// ----------------------------------------------------------------------------
module lmts_cell (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift_en,
    input  logic [7:0] data_in,
    output logic [7:0] data_out
);

    logic [7:0] data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= 8'd0;
        end
        else if (shift_en)
        begin
            data_reg <= data_in;
        end
    end

    assign data_out = data_reg;

endmodule

// File: hdl/lmts_row.sv
// ----------------------------------------------------------------------------
// lmts_row
// A text row as a chain of byte cells shifting towards the head.
// ----------------------------------------------------------------------------
module lmts_row #(
    parameter int ROW_BYTES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift_en,
    input  logic [7:0] tail_in,
    output logic [7:0] head
);

    logic [7:0] link [ROW_BYTES+1];

    assign link[ROW_BYTES] = tail_in;

    for (genvar k = 0; k < ROW_BYTES; k++)
    begin : g_cell
        lmts_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .data_in  (link[k+1]),
            .data_out (link[k])
        );
    end

    assign head = link[0];

endmodule

// File: hdl/led_matrix_text_scroller.sv
// Sequence: load and unknown commands pass the prepare and finish states; scroll
// adds a shift state between them; clear, write and read rotate the row between
// them, as every byte of the row passes the head of its cell chain once, fed by the font RAM read port.
// Flow: the sequencer returns to its idle state between items, so an item is taken
// only once the last one is finished; the next item is taken while a result waits.
// Reset: frame bytes, phases, held codes and halves clear at once; the font
// RAM holds nothing until loaded.
// ----------------------------------------------------------------------------
// led_matrix_text_scroller
// Font store, two-row frame of shifting byte cells, and the command sequencer.
// ----------------------------------------------------------------------------
module led_matrix_text_scroller #(
    parameter int ROWS          = lmts_pkg::ROWS_DEF,
    parameter int CHARS_PER_ROW = lmts_pkg::CHARS_PER_ROW_DEF,
    parameter int GLYPHS        = lmts_pkg::GLYPHS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lmts_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output lmts_pkg::out_item_t out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int ROW_BYTES  = CHARS_PER_ROW * lmts_pkg::COLS_PER_CHAR;
    localparam int IW         = $clog2(ROW_BYTES);
    localparam int FONT_DEPTH = GLYPHS * 8;
    localparam int AW         = $clog2(FONT_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PREP   = 5'b00010,
        ST_ROT    = 5'b00100,
        ST_SHIFT  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    lmts_pkg::in_item_t item_reg;
    logic               double_reg;
    logic [7:0]         first_code_reg;
    logic [IW-1:0]      idx_reg;
    logic [7:0]         rd_reg;
    logic               out_valid_reg;
    lmts_pkg::out_item_t out_reg;
    logic [2:0]         phase_reg [ROWS];
    logic [7:0]         held_reg  [ROWS];
    logic               half_reg  [ROWS];

    logic       row_idx;
    logic [2:0] ph;
    logic [7:0] held_new;
    logic [7:0] head [ROWS];
    logic [7:0] head_sel;
    logic [7:0] font_rdata;
    logic [7:0] col_byte;
    logic [7:0] tail;
    logic [ROWS-1:0] shift_en;
    logic [2:0] addr_col;
    logic [7:0] sel_code;
    logic [7:0] glyph;
    logic [8:0] diff;
    logic [2:0] col_sel;
    logic [10:0] addr_full;
    logic [AW-1:0] font_raddr;
    logic       font_we;
    logic [10:0] waddr_full;
    logic       slot_ok;
    logic       slot_hit;
    logic       rot_last;
    logic       apb_write;

    assign row_idx  = (ROWS > 1) ? item_reg.row : 1'b0;
    assign ph       = phase_reg[row_idx];
    assign held_new = (ph == 3'd0) ? item_reg.code : held_reg[row_idx];
    assign head_sel = head[row_idx];
    assign slot_ok  = {2'b00, item_reg.char_slot} < 5'(CHARS_PER_ROW);
    assign slot_hit = slot_ok && (8'(idx_reg >> 3) == {5'd0, item_reg.char_slot});
    assign rot_last = idx_reg == IW'(ROW_BYTES - 1);

    // Configuration port.
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == lmts_pkg::REG_FIRST_CODE) ? {24'd0, first_code_reg}
                                                              : {31'd0, double_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            double_reg     <= 1'b0;
            first_code_reg <= lmts_pkg::FIRST_CODE_RESET;
        end
        else if (apb_write)
        begin
            if (paddr[2] == lmts_pkg::REG_DOUBLE_SIZE)
            begin
                double_reg <= pwdata[0];
            end
            else
            begin
                first_code_reg <= pwdata[7:0];
            end
        end
    end

    // Font address: the column fetched is the one needed at the next step.
    always_comb
    begin
        addr_col = (state_reg == ST_PREP) ? 3'd0 : 3'(idx_reg + IW'(1));
        case (item_reg.command)
            lmts_pkg::CMD_WRITE:
            begin
                sel_code = item_reg.code;
                col_sel  = double_reg ? {item_reg.char_slot[0], addr_col[2:1]} : addr_col;
            end
            lmts_pkg::CMD_SCROLL:
            begin
                sel_code = held_new;
                col_sel  = double_reg ? {half_reg[row_idx], ph[2:1]} : ph;
            end
            default:
            begin
                sel_code = first_code_reg;
                col_sel  = addr_col;
            end
        endcase
        diff  = {1'b0, sel_code} - {1'b0, first_code_reg};
        glyph = (sel_code >= first_code_reg && diff < 9'(GLYPHS)) ? diff[7:0] : 8'd0;
        addr_full  = {glyph, col_sel};
        font_raddr = addr_full[AW-1:0];
    end

    assign font_we    = (state_reg == ST_PREP) && (item_reg.command == lmts_pkg::CMD_LOAD)
                        && ({1'b0, item_reg.code} < 9'(GLYPHS));
    assign waddr_full = {item_reg.code, item_reg.glyph_line};

    lmts_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font (
        .clk   (clk),
        .we    (font_we),
        .waddr (waddr_full[AW-1:0]),
        .wdata (item_reg.font_byte),
        .raddr (font_raddr),
        .rdata (font_rdata)
    );

    assign col_byte = double_reg
                      ? lmts_pkg::expand_nibble(row_idx ? font_rdata[7:4] : font_rdata[3:0])
                      : font_rdata;

    always_comb
    begin
        tail     = head_sel;
        shift_en = '0;
        if (state_reg == ST_ROT)
        begin
            case (item_reg.command)
                lmts_pkg::CMD_CLEAR_ALL:
                begin
                    tail     = font_rdata;
                    shift_en = '1;
                end
                lmts_pkg::CMD_CLEAR_ROW:
                begin
                    tail = font_rdata;
                end
                lmts_pkg::CMD_WRITE:
                begin
                    tail = slot_hit ? col_byte : head_sel;
                end
                default:
                begin
                    tail = head_sel;
                end
            endcase
            if (item_reg.command != lmts_pkg::CMD_CLEAR_ALL)
            begin
                shift_en[row_idx] = 1'b1;
            end
        end
        else if (state_reg == ST_SHIFT)
        begin
            tail              = (held_new != 8'd0) ? col_byte : head_sel;
            shift_en[row_idx] = 1'b1;
        end
    end

    for (genvar r = 0; r < ROWS; r++)
    begin : g_row
        lmts_row #(
            .ROW_BYTES (ROW_BYTES)
        ) u_row (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en[r]),
            .tail_in  (tail),
            .head     (head[r])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (item_reg.command == lmts_pkg::CMD_SCROLL)
                begin
                    state_next = ST_SHIFT;
                end
                else if (item_reg.command == lmts_pkg::CMD_CLEAR_ALL
                         || item_reg.command == lmts_pkg::CMD_CLEAR_ROW
                         || item_reg.command == lmts_pkg::CMD_WRITE
                         || item_reg.command == lmts_pkg::CMD_READ)
                begin
                    state_next = ST_ROT;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_ROT:
            begin
                if (rot_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SHIFT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = state_reg == ST_IDLE;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
        if (state_reg == ST_PREP)
        begin
            rd_reg <= 8'd0;
        end
        else if (state_reg == ST_ROT && item_reg.command == lmts_pkg::CMD_READ
                 && 8'(idx_reg) == {2'b00, item_reg.frame_column})
        begin
            rd_reg <= head_sel;
        end
        if (state_reg == ST_FINISH && (!out_valid_reg || out_ready))
        begin
            out_reg.read_data    <= rd_reg;
            out_reg.scroll_phase <= phase_reg[row_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < ROWS; r++)
            begin
                phase_reg[r] <= 3'd0;
                held_reg[r]  <= 8'd0;
                half_reg[r]  <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_PREP)
            begin
                idx_reg <= '0;
                case (item_reg.command)
                    lmts_pkg::CMD_CLEAR_ALL:
                    begin
                        for (int r = 0; r < ROWS; r++)
                        begin
                            phase_reg[r] <= 3'd0;
                            held_reg[r]  <= 8'd0;
                        end
                    end
                    lmts_pkg::CMD_CLEAR_ROW:
                    begin
                        phase_reg[row_idx] <= 3'd0;
                        held_reg[row_idx]  <= 8'd0;
                        half_reg[row_idx]  <= 1'b0;
                    end
                    lmts_pkg::CMD_WRITE:
                    begin
                        if (slot_ok)
                        begin
                            half_reg[row_idx] <= double_reg && !item_reg.char_slot[0];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (state_reg == ST_ROT)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
            else if (state_reg == ST_SHIFT)
            begin
                held_reg[row_idx]  <= (ph == 3'd7) ? 8'd0 : held_new;
                phase_reg[row_idx] <= ph + 3'd1;
                if (ph == 3'd7 && double_reg)
                begin
                    half_reg[row_idx] <= !half_reg[row_idx];
                end
            end
            if (state_reg == ST_FINISH && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// File: dv/tb_led_matrix_text_scroller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_matrix_text_scroller
// Self-checking testbench: commands go in through a valid/ready channel, and
// every result is checked against a predictor of the font, frame and scroll
// state. Both settings are swept through the APB port between phases.
// ----------------------------------------------------------------------------
module tb_led_matrix_text_scroller;

    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam logic [2:0] ADDR_DOUBLE_SIZE = 3'(4 * lmts_pkg::REG_DOUBLE_SIZE);
    localparam logic [2:0] ADDR_FIRST_CODE  = 3'(4 * lmts_pkg::REG_FIRST_CODE);
    localparam int GLYPHS_DEF = lmts_pkg::GLYPHS_DEF;
    localparam int COLS_PER_CHAR = lmts_pkg::COLS_PER_CHAR;
    localparam int ROW_BYTES = lmts_pkg::CHARS_PER_ROW_DEF * COLS_PER_CHAR;
    localparam int LOADED_GLYPHS = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 90;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    lmts_pkg::in_item_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    lmts_pkg::out_item_t out_item;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    led_matrix_text_scroller u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 clk = ~clk;

    // Predicted block state.
    logic [7:0] font_mem [GLYPHS_DEF*8];
    logic [7:0] frame_mem [2][ROW_BYTES];
    logic [2:0] row_phase [2];
    logic [7:0] row_held [2];
    logic       row_half [2];
    logic       dbl_mode;
    logic [7:0] base_code;

    lmts_pkg::in_item_t  cmd_queue [$];
    lmts_pkg::out_item_t result_queue [$];
    int  mismatches = 0;
    int  cycles = 0;
    bit  in_taken = 0;
    bit  calm = 0;
    int  send_gap = 0;
    int  recv_gap = 0;

    function automatic int glyph_index(logic [7:0] code);
        if (code < base_code || int'(code) - int'(base_code) >= GLYPHS_DEF)
            return 0;
        return int'(code) - int'(base_code);
    endfunction

    // Only a few glyphs are loaded, so looked-up codes are kept to those.
    function automatic bit glyph_loaded(int g);
        return g < LOADED_GLYPHS || g == GLYPHS_DEF - 1;
    endfunction

    function automatic logic [7:0] usable_code(logic [7:0] code);
        if (glyph_loaded(glyph_index(code)))
            return code;
        return 8'(base_code + 8'($urandom_range(0, LOADED_GLYPHS - 1)));
    endfunction

    function automatic logic [7:0] glyph_column(logic [7:0] code, logic row, logic half,
                                               int col);
        int g;
        logic [7:0] src;
        logic [3:0] nib;
        logic [7:0] res;
        g = glyph_index(code);
        if (!dbl_mode)
            return font_mem[g*8 + col];
        src = font_mem[g*8 + half*4 + col/2];
        nib = row ? src[7:4] : src[3:0];
        for (int k = 0; k < 4; k++)
        begin
            res[2*k]   = nib[k];
            res[2*k+1] = nib[k];
        end
        return res;
    endfunction

    function automatic void blank_row(int r);
        for (int c = 0; c < ROW_BYTES; c++)
            frame_mem[r][c] = font_mem[c % COLS_PER_CHAR];
    endfunction

    function automatic lmts_pkg::out_item_t predict_frame(lmts_pkg::in_item_t it);
        lmts_pkg::out_item_t res;
        logic [7:0] first;
        logic [2:0] ph;
        int r;
        r = it.row;
        res = '0;
        case (it.command)
            lmts_pkg::CMD_LOAD:
                if (it.code < GLYPHS_DEF)
                    font_mem[it.code*8 + it.glyph_line] = it.font_byte;
            lmts_pkg::CMD_CLEAR_ALL:
                for (int i = 0; i < 2; i++)
                begin
                    blank_row(i);
                    row_phase[i] = '0;
                    row_held[i] = '0;
                end
            lmts_pkg::CMD_CLEAR_ROW:
            begin
                blank_row(r);
                row_phase[r] = '0;
                row_held[r] = '0;
                row_half[r] = 1'b0;
            end
            lmts_pkg::CMD_WRITE:
            begin
                for (int c = 0; c < COLS_PER_CHAR; c++)
                    frame_mem[r][it.char_slot*8 + c] =
                        glyph_column(it.code, it.row, it.char_slot[0], c);
                row_half[r] = dbl_mode ? ~it.char_slot[0] : 1'b0;
            end
            lmts_pkg::CMD_SCROLL:
            begin
                first = frame_mem[r][0];
                ph = row_phase[r];
                if (ph == 0)
                    row_held[r] = it.code;
                for (int c = 0; c < ROW_BYTES - 1; c++)
                    frame_mem[r][c] = frame_mem[r][c+1];
                frame_mem[r][ROW_BYTES-1] = (row_held[r] != 0)
                    ? glyph_column(row_held[r], it.row, row_half[r], ph) : first;
                if (ph == 7)
                begin
                    row_held[r] = '0;
                    if (dbl_mode)
                        row_half[r] = ~row_half[r];
                end
                row_phase[r] = ph + 3'd1;
            end
            lmts_pkg::CMD_READ:
                res.read_data = frame_mem[r][it.frame_column];
            default: ;
        endcase
        res.scroll_phase = row_phase[r];
        return res;
    endfunction

    // Acceptance, prediction and checking at the rising edge.
    always @(posedge clk)
    begin
        lmts_pkg::out_item_t want;
        cycles++;
        in_taken = in_valid && in_ready;
        if (in_taken)
            result_queue.push_back(predict_frame(in_item));
        if (out_valid && out_ready)
        begin
            if (result_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", out_item);
            end
            else
            begin
                want = result_queue.pop_front();
                if (out_item.read_data !== want.read_data ||
                    out_item.scroll_phase !== want.scroll_phase)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected data %h phase %0d, got data %h phase %0d",
                                 want.read_data, want.scroll_phase,
                                 out_item.read_data, out_item.scroll_phase);
                end
            end
        end
    end

    // Command driver; each signal gets a single assignment per edge.
    always @(negedge clk)
    begin
        logic nv;
        lmts_pkg::in_item_t ni;
        nv = in_valid;
        ni = in_item;
        if (!rst_n)
            nv = 1'b0;
        else if (!in_valid || in_taken)
        begin
            nv = 1'b0;
            if (send_gap > 0)
                send_gap--;
            else if (cmd_queue.size() > 0)
            begin
                ni = cmd_queue.pop_front();
                nv = 1'b1;
                if (!calm && $urandom_range(0, 11) == 0)
                    send_gap = $urandom_range(1, 17);
            end
        end
        in_valid <= nv;
        in_item <= ni;
    end

    always @(negedge clk)
    begin
        if (recv_gap > 0)
        begin
            recv_gap--;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 11) == 0)
        begin
            recv_gap = $urandom_range(0, 16);
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n;
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("led_matrix_text_scroller regression: fail");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ADDR_DOUBLE_SIZE)
            dbl_mode = value[0];
        else
            base_code = value[7:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Checked at the rising edge, where the driven inputs are settled.
    task automatic drain();
        do
            @(posedge clk);
        while (cmd_queue.size() != 0 || in_valid || result_queue.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic void push_cmd(logic [2:0] cmd, logic row, logic [2:0] slot,
                                     logic [7:0] code, logic [5:0] col);
        lmts_pkg::in_item_t it;
        it = '{command: cmd, row: row, char_slot: slot, code: code,
               glyph_line: 3'($urandom), font_byte: 8'($urandom), frame_column: col};
        cmd_queue.push_back(it);
    endfunction

    function automatic void push_random(int count);
        lmts_pkg::in_item_t it;
        logic [7:0] code;
        int pick;
        while (count > 0)
        begin
            it = lmts_pkg::in_item_t'($urandom);
            it.command = lmts_pkg::CMD_READ;
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                // A full character scrolled into one row, at random phase start.
                code = ($urandom_range(0, 4) == 0) ? 8'd0 : usable_code(8'($urandom));
                it.command = lmts_pkg::CMD_SCROLL;
                for (int i = 0; i < 8; i++)
                begin
                    it.code = (i == 0) ? code : usable_code(8'($urandom));
                    cmd_queue.push_back(it);
                end
                count -= 8;
                continue;
            end
            else if (pick < 40) it.command = lmts_pkg::CMD_LOAD;
            else if (pick < 43) it.command = lmts_pkg::CMD_CLEAR_ALL;
            else if (pick < 47) it.command = lmts_pkg::CMD_CLEAR_ROW;
            else if (pick < 65) it.command = lmts_pkg::CMD_WRITE;
            else if (pick < 72) it.command = lmts_pkg::CMD_SCROLL;
            else if (pick < 97) it.command = lmts_pkg::CMD_READ;
            else it.command = ($urandom_range(0, 1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
            if (it.command == lmts_pkg::CMD_WRITE || it.command == lmts_pkg::CMD_SCROLL)
                it.code = usable_code(it.code);
            cmd_queue.push_back(it);
            count--;
        end
    endfunction

    initial
    begin
        logic [7:0] fc_sweep [6];
        logic       ds_sweep [6];
        lmts_pkg::in_item_t it;
        fc_sweep = '{8'd32, 8'd32, 8'd0, 8'd255, 8'd128, 8'd0};
        ds_sweep = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        dbl_mode = 1'b0;
        base_code = lmts_pkg::FIRST_CODE_RESET;
        for (int i = 0; i < GLYPHS_DEF*8; i++)
            font_mem[i] = '0;
        for (int r = 0; r < 2; r++)
        begin
            for (int c = 0; c < ROW_BYTES; c++)
                frame_mem[r][c] = '0;
            row_phase[r] = '0;
            row_held[r] = '0;
            row_half[r] = 1'b0;
        end
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Every glyph that is looked up must be written first.
        for (int g = 0; g < GLYPHS_DEF; g++)
            if (glyph_loaded(g))
                for (int l = 0; l < 8; l++)
                begin
                    it = '0;
                    it.command = lmts_pkg::CMD_LOAD;
                    it.code = 8'(g);
                    it.glyph_line = 3'(l);
                    it.font_byte = 8'($urandom);
                    cmd_queue.push_back(it);
                end
        drain();

        for (int p = 0; p < 6; p++)
        begin
            reg_write(ADDR_DOUBLE_SIZE, {31'd0, ds_sweep[p]});
            reg_write(ADDR_FIRST_CODE, {24'd0, (p == 4) ? 8'($urandom) : fc_sweep[p]});
            if (p == 0)
            begin
                push_cmd(lmts_pkg::CMD_READ, 1'b1, 3'd7, 8'd0, 6'd63);
                push_cmd(lmts_pkg::CMD_CLEAR_ALL, 1'b0, 3'd0, 8'd0, 6'd0);
                push_cmd(lmts_pkg::CMD_WRITE, 1'b0, 3'd0, 8'd31, 6'd0);
                push_cmd(lmts_pkg::CMD_WRITE, 1'b1, 3'd7, 8'd255, 6'd0);
                push_cmd(lmts_pkg::CMD_WRITE, 1'b0, 3'd3, 8'd159, 6'd0);
                push_cmd(lmts_pkg::CMD_WRITE, 1'b1, 3'd4, 8'd160, 6'd0);
                push_cmd(lmts_pkg::CMD_READ, 1'b0, 3'd0, 8'd0, 6'd0);
                push_cmd(lmts_pkg::CMD_READ, 1'b1, 3'd0, 8'd0, 6'd63);
                for (int i = 0; i < 8; i++)
                    push_cmd(lmts_pkg::CMD_SCROLL, 1'b0, 3'd0, 8'd0, 6'd0);
                push_cmd(lmts_pkg::CMD_SCROLL, 1'b1, 3'd0, 8'd40, 6'd0);
                push_cmd(lmts_pkg::CMD_CLEAR_ROW, 1'b1, 3'd0, 8'd0, 6'd0);
                push_cmd(CMD_SPARE_6, 1'b0, 3'd0, 8'd0, 6'd0);
                push_cmd(CMD_SPARE_7, 1'b1, 3'd0, 8'd0, 6'd0);
                push_cmd(lmts_pkg::CMD_LOAD, 1'b0, 3'd0, 8'd255, 6'd0);
                push_cmd(lmts_pkg::CMD_READ, 1'b0, 3'd0, 8'd0, 6'd63);
            end
            calm = (p == 5);
            push_random(90);
            // Held codes are dropped before the first code changes.
            push_cmd(lmts_pkg::CMD_CLEAR_ALL, 1'b0, 3'd0, 8'd0, 6'd0);
            drain();
        end

        if (mismatches == 0)
            $display("led_matrix_text_scroller regression: pass");
        else
            $display("led_matrix_text_scroller regression: fail");
        $finish;
    end

endmodule

// File: sim.f
hdl/lmts_pkg.sv
hdl/lmts_ram.sv
hdl/lmts_cell.sv
hdl/lmts_row.sv
hdl/led_matrix_text_scroller.sv
dv/tb_led_matrix_text_scroller.sv
